>>> hdl/lrk_pkg.sv
// Shared constants, register indexes and pipeline payload types of the luma range keyer.
package lrk_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int FRACTION_BITS = 12;
    localparam int MASK_W        = FRACTION_BITS + 1;
    localparam int ALPHA_W       = 16;
    localparam int BANDS         = 3;

    localparam int STEPS      = 3;
    localparam int DIV_STAGES = (MASK_W + STEPS - 1) / STEPS;
    localparam int QUO_W      = DIV_STAGES * STEPS;
    localparam int LEAD       = QUO_W - MASK_W + 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = PIXEL_BITS;

    localparam logic [MASK_W-1:0]     MASK_ONE    = MASK_W'(1) << FRACTION_BITS;
    localparam logic [PIXEL_BITS-1:0] BOUND_RESET = PIXEL_BITS'(1) << (FRACTION_BITS - 1);

    localparam int BAND_BRIGHT = 0;
    localparam int BAND_MID    = 1;
    localparam int BAND_DARK   = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BRIGHT_HIGH = 3'd0,
        REG_BRIGHT_LOW  = 3'd1,
        REG_MID_HIGH    = 3'd2,
        REG_MID_LOW     = 3'd3,
        REG_DARK_HIGH   = 3'd4,
        REG_DARK_LOW    = 3'd5,
        REG_INVERT_RAMP = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] high;
        logic [PIXEL_BITS-1:0] low;
    } bounds_t;

    typedef struct packed {
        logic                  in_window;
        logic [PIXEL_BITS-1:0] rem;
        logic [PIXEL_BITS-1:0] divisor;
        logic [QUO_W-1:0]      quo;
        logic [STEPS-1:0]      feed;
    } band_t;

    typedef struct packed {
        band_t [BANDS-1:0]  band;
        logic [ALPHA_W-1:0] alpha;
    } pipe_t;

endpackage

>>> hdl/lrk_prep.sv
// Entry stage: window test, offset from the low bound and floored range for each band.
module lrk_prep
    import lrk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_BITS-1:0] luma,
    input  logic [ALPHA_W-1:0]    alpha_in,
    input  bounds_t [BANDS-1:0]   bounds,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pipe_t                 out_pipe
);

    logic  valid_reg;
    logic  valid_next;
    logic  advance;
    pipe_t pipe_reg;
    pipe_t pipe_next;

    assign advance   = !valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

    always_comb
    begin
        logic [PIXEL_BITS-1:0] diff;
        logic [PIXEL_BITS-1:0] span;
        pipe_next       = pipe_reg;
        pipe_next.alpha = alpha_in;
        for (int b = 0; b < BANDS; b++)
        begin
            diff = luma - bounds[b].low;
            span = bounds[b].high - bounds[b].low;
            if (span == '0)
            begin
                span = PIXEL_BITS'(1);
            end
            pipe_next.band[b].in_window = (luma >= bounds[b].low) && (luma <= bounds[b].high);
            pipe_next.band[b].rem       = diff >> LEAD;
            pipe_next.band[b].divisor   = span;
            pipe_next.band[b].quo       = '0;
            pipe_next.band[b].feed      = STEPS'(diff[LEAD-1:0]) << (STEPS - LEAD);
        end
        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            pipe_reg <= pipe_next;
        end
    end

endmodule

>>> hdl/lrk_div_stage.sv
// One divider stage: three restoring quotient steps (STEPS) for all three bands.
module lrk_div_stage
    import lrk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  pipe_t in_pipe,
    output logic  out_valid,
    input  logic  out_stall,
    output pipe_t out_pipe
);

    logic  valid_reg;
    logic  valid_next;
    logic  advance;
    pipe_t pipe_reg;
    pipe_t pipe_next;

    assign advance   = !valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

    always_comb
    begin
        logic [PIXEL_BITS:0] trial;
        logic [PIXEL_BITS:0] wide_div;
        logic                take;
        pipe_next = in_pipe;
        for (int b = 0; b < BANDS; b++)
        begin
            wide_div = {1'b0, in_pipe.band[b].divisor};
            for (int s = 0; s < STEPS; s++)
            begin
                trial = {pipe_next.band[b].rem, pipe_next.band[b].feed[STEPS-1]};
                take  = trial >= wide_div;
                if (take)
                begin
                    pipe_next.band[b].rem = PIXEL_BITS'(trial - wide_div);
                end
                else
                begin
                    pipe_next.band[b].rem = trial[PIXEL_BITS-1:0];
                end
                pipe_next.band[b].quo  = {pipe_next.band[b].quo[QUO_W-2:0], take};
                pipe_next.band[b].feed = {pipe_next.band[b].feed[STEPS-2:0], 1'b0};
            end
        end
        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            pipe_reg <= pipe_next;
        end
    end

endmodule

>>> hdl/lrk_out.sv
// Output stage: window gating, optional ramp inversion and the result register.
module lrk_out
    import lrk_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pipe_t                         in_pipe,
    input  logic                          invert,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [BANDS-1:0][MASK_W-1:0]  masks,
    output logic [ALPHA_W-1:0]            alpha
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         advance;
    logic [BANDS-1:0][MASK_W-1:0] masks_reg;
    logic [BANDS-1:0][MASK_W-1:0] masks_next;
    logic [ALPHA_W-1:0]           alpha_reg;

    assign advance   = !valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign out_valid = valid_reg;
    assign masks     = masks_reg;
    assign alpha     = alpha_reg;

    always_comb
    begin
        logic [MASK_W-1:0] factor;
        for (int b = 0; b < BANDS; b++)
        begin
            factor = in_pipe.band[b].quo[MASK_W-1:0];
            if (!in_pipe.band[b].in_window)
            begin
                masks_next[b] = '0;
            end
            else if (invert)
            begin
                masks_next[b] = MASK_ONE - factor;
            end
            else
            begin
                masks_next[b] = factor;
            end
        end
        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            masks_reg <= masks_next;
            alpha_reg <= in_pipe.alpha;
        end
    end

endmodule

>>> hdl/luma_range_mask_keyer.sv
// Top level of the three-band luma range keyer: configuration registers and pipeline.
//
//   Channel  Handshake               Payload
//   input    in_valid / in_stall     luma, alpha_in
//   output   out_valid / out_stall   bright_mask, mid_mask, dark_mask, alpha_out
//   config   cfg_write               cfg_index, cfg_data
//
// A transfer enters every cycle while in_stall is low; each result passes, in order, through
// one entry stage, five divider stages of three quotient steps each, and the output register.
// Reset clears the pipeline valid bits and loads the register reset values.
// A stall holds only the stages that are full, so bubbles close up and nothing is lost.
module luma_range_mask_keyer
    import lrk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIXEL_BITS-1:0]  luma,
    input  logic [ALPHA_W-1:0]     alpha_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MASK_W-1:0]      bright_mask,
    output logic [MASK_W-1:0]      mid_mask,
    output logic [MASK_W-1:0]      dark_mask,
    output logic [ALPHA_W-1:0]     alpha_out,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bounds_t [BANDS-1:0]          bounds_reg;
    logic                         invert_reg;
    logic [BANDS-1:0][MASK_W-1:0] masks;

    pipe_t link_pipe  [DIV_STAGES+1];
    logic  link_valid [DIV_STAGES+1];
    logic  link_stall [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BANDS; b++)
            begin
                bounds_reg[b].high <= BOUND_RESET;
                bounds_reg[b].low  <= BOUND_RESET;
            end
            invert_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BRIGHT_HIGH: bounds_reg[BAND_BRIGHT].high <= cfg_data[PIXEL_BITS-1:0];
                REG_BRIGHT_LOW:  bounds_reg[BAND_BRIGHT].low  <= cfg_data[PIXEL_BITS-1:0];
                REG_MID_HIGH:    bounds_reg[BAND_MID].high    <= cfg_data[PIXEL_BITS-1:0];
                REG_MID_LOW:     bounds_reg[BAND_MID].low     <= cfg_data[PIXEL_BITS-1:0];
                REG_DARK_HIGH:   bounds_reg[BAND_DARK].high   <= cfg_data[PIXEL_BITS-1:0];
                REG_DARK_LOW:    bounds_reg[BAND_DARK].low    <= cfg_data[PIXEL_BITS-1:0];
                REG_INVERT_RAMP: invert_reg                   <= cfg_data[0];
                default:         invert_reg                   <= invert_reg;
            endcase
        end
    end

    lrk_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .luma      (luma),
        .alpha_in  (alpha_in),
        .bounds    (bounds_reg),
        .out_valid (link_valid[0]),
        .out_stall (link_stall[0]),
        .out_pipe  (link_pipe[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        lrk_div_stage u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_stall  (link_stall[i]),
            .in_pipe   (link_pipe[i]),
            .out_valid (link_valid[i+1]),
            .out_stall (link_stall[i+1]),
            .out_pipe  (link_pipe[i+1])
        );
    end

    lrk_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[DIV_STAGES]),
        .in_stall  (link_stall[DIV_STAGES]),
        .in_pipe   (link_pipe[DIV_STAGES]),
        .invert    (invert_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .masks     (masks),
        .alpha     (alpha_out)
    );

    assign bright_mask = masks[BAND_BRIGHT];
    assign mid_mask    = masks[BAND_MID];
    assign dark_mask   = masks[BAND_DARK];

endmodule
